// File: src/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, switched off while rst_ni is low.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, switched off while rst_ni is low.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/kgpu_pkg.sv
// Shared types, codes, limits and the carry offset table of the keyframe gate.
`default_nettype none

package kgpu_pkg;

  // Stream widths, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 104;

  // Item opcodes.
  localparam logic [1:0] OP_VIDEO = 2'd0;
  localparam logic [1:0] OP_AUDIO = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_FORWARD = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_KEEP    = 2'd2;

  // Codec selections.
  localparam logic [1:0] CODEC_H264 = 2'd0;
  localparam logic [1:0] CODEC_H265 = 2'd1;

  // Configuration register indexes.
  localparam logic [1:0] REG_SESSION = 2'd0;
  localparam logic [1:0] REG_CODEC   = 2'd1;
  localparam logic [1:0] REG_JUMP    = 2'd2;

  // Limits.
  localparam logic [23:0] MAX_VIDEO_BYTES   = 24'd4194304;
  localparam logic [23:0] MAX_AUDIO_BYTES   = 24'd8192;
  localparam logic [23:0] SHORT_AUDIO_BYTES = 24'd7;
  localparam logic [15:0] JUMP_RESET        = 16'd3000;
  localparam logic [28:0] WRAP_MS           = 29'd95443717;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified item as it travels through the queue.
  typedef struct packed {
    logic [1:0]  op;
    logic        vsize_ok;
    logic        asize_ok;
    logic        audio_short;
    logic        start_nal;
    logic [23:0] size;
    logic [26:0] stamp;
  } cls_t;

  // floor(k * 2^33 / 90) for a carry count k.
  function automatic logic [29:0] wrap_offset(input logic [2:0] k);
    logic [29:0] off;
    case (k)
      3'd0:    off = 30'd0;
      3'd1:    off = 30'd95443717;
      3'd2:    off = 30'd190887435;
      3'd3:    off = 30'd286331153;
      3'd4:    off = 30'd381774870;
      3'd5:    off = 30'd477218588;
      3'd6:    off = 30'd572662306;
      3'd7:    off = 30'd668106023;
      default: off = 30'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// File: src/kgpu_front.sv
// Front end: decodes the frame header and size limits of an incoming item.
`default_nettype none

module kgpu_front (
  input  wire logic [1:0]  opcode_i,
  input  wire logic [23:0] frame_size_i,
  input  wire logic [7:0]  head_byte0_i,
  input  wire logic [7:0]  head_byte1_i,
  input  wire logic [7:0]  head_byte2_i,
  input  wire logic [7:0]  head_byte3_i,
  input  wire logic [7:0]  head_byte4_i,
  input  wire logic [26:0] stamp_ms_i,
  input  wire logic [1:0]  codec_i,
  output kgpu_pkg::cls_t   cls_o
);

  // NAL unit types that may open a recording.
  localparam logic [4:0] H264_IDR = 5'd5;
  localparam logic [4:0] H264_SPS = 5'd7;
  localparam logic [4:0] H264_PPS = 5'd8;
  localparam logic [5:0] H265_IDR_W = 6'd19;
  localparam logic [5:0] H265_IDR_N = 6'd20;
  localparam logic [5:0] H265_VPS   = 6'd32;
  localparam logic [5:0] H265_SPS   = 6'd33;
  localparam logic [5:0] H265_PPS   = 6'd34;

  logic [7:0] hb0, hb1, hb2, hb3, hb4;
  logic       hdr3, hdr4;
  logic [7:0] nal;
  logic [4:0] t264;
  logic [5:0] t265;
  logic       nal_ok;

  // Bytes past the end of the frame read as zero.
  assign hb0 = (frame_size_i > 24'd0) ? head_byte0_i : 8'd0;
  assign hb1 = (frame_size_i > 24'd1) ? head_byte1_i : 8'd0;
  assign hb2 = (frame_size_i > 24'd2) ? head_byte2_i : 8'd0;
  assign hb3 = (frame_size_i > 24'd3) ? head_byte3_i : 8'd0;
  assign hb4 = (frame_size_i > 24'd4) ? head_byte4_i : 8'd0;

  // Four-byte and three-byte start codes.
  assign hdr4 = (hb0 == 8'd0) && (hb1 == 8'd0) && (hb2 == 8'd0) && (hb3 == 8'd1);
  assign hdr3 = (hb0 == 8'd0) && (hb1 == 8'd0) && (hb2 == 8'd1);
  assign nal  = hdr4 ? hb4 : hb3;

  // NAL type check for the selected codec.
  assign t264 = nal[4:0];
  assign t265 = nal[6:1];
  always_comb begin
    case (codec_i)
      kgpu_pkg::CODEC_H264:
        nal_ok = (t264 == H264_IDR) || (t264 == H264_SPS) || (t264 == H264_PPS);
      kgpu_pkg::CODEC_H265:
        nal_ok = (t265 == H265_VPS) || (t265 == H265_SPS) || (t265 == H265_PPS) ||
                 (t265 == H265_IDR_W) || (t265 == H265_IDR_N);
      default:
        nal_ok = 1'b0;
    endcase
  end

  // Classified item.
  always_comb begin
    cls_o.op          = opcode_i;
    cls_o.vsize_ok    = (frame_size_i <= kgpu_pkg::MAX_VIDEO_BYTES);
    cls_o.asize_ok    = (frame_size_i <= kgpu_pkg::MAX_AUDIO_BYTES);
    cls_o.audio_short = (frame_size_i <= kgpu_pkg::SHORT_AUDIO_BYTES);
    cls_o.start_nal   = (hdr3 || hdr4) && nal_ok;
    cls_o.size        = frame_size_i;
    cls_o.stamp       = stamp_ms_i;
  end

endmodule

`default_nettype wire

// File: src/kgpu_fifo.sv
// Short queue of classified items between the front and the back.
`default_nettype none

module kgpu_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  kgpu_pkg::cls_t      data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output kgpu_pkg::cls_t      data_o
);

  kgpu_pkg::cls_t                     mem_q [kgpu_pkg::QUEUE_DEPTH];
  logic [kgpu_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [kgpu_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [kgpu_pkg::QCNT_W-1:0]        count_q, count_d;
  logic                               do_push, do_pop;

  localparam logic [kgpu_pkg::QPTR_W-1:0] LAST_PTR = kgpu_pkg::QPTR_W'(kgpu_pkg::QUEUE_DEPTH - 1);
  localparam logic [kgpu_pkg::QCNT_W-1:0] FULL_CNT = kgpu_pkg::QCNT_W'(kgpu_pkg::QUEUE_DEPTH);

  assign full_o  = (count_q == FULL_CNT);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/kgpu_back.sv
// Back end: session state, timestamp unwrapping, byte count and result register.
`default_nettype none

module kgpu_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  output logic [1:0]       codec_o,
  // Classified items from the queue
  input  wire logic        item_valid_i,
  input  kgpu_pkg::cls_t   item_i,
  output logic             item_pop_o,
  // Result register
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [29:0]      ext_o,
  output logic [29:0]      rec_o,
  output logic [39:0]      total_o
);

  // Configuration registers.
  logic        session_q, session_d;
  logic [1:0]  codec_q, codec_d;
  logic [15:0] jump_q, jump_d;

  // Session state.
  logic        started_q, started_d;
  logic        have_first_q, have_first_d;
  logic [26:0] first_q, first_d;
  logic [26:0] last_q, last_d;
  logic [2:0]  wrap_q, wrap_d;
  logic [39:0] bytes_q, bytes_d;

  // Result register.
  logic        out_valid_q;
  logic [1:0]  status_q, status_d;
  logic [29:0] ext_q, ext_d;
  logic [29:0] rec_q, rec_d;
  logic [39:0] total_q;

  logic        take;
  logic [26:0] first_eff, last_eff;
  logic        back_step;
  logic [26:0] fwd_diff;
  logic [28:0] wsum;
  logic        jump_bad;
  logic [2:0]  k_new;
  logic [29:0] ext_new;
  logic [30:0] rec_new;
  logic        vid_ok;
  logic        codec_known;

  assign take       = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o = take;
  assign codec_o    = codec_q;
  assign codec_known = (codec_q == kgpu_pkg::CODEC_H264) || (codec_q == kgpu_pkg::CODEC_H265);

  // The first admitted video frame anchors both stored stamps.
  assign first_eff = have_first_q ? first_q : item_i.stamp;
  assign last_eff  = have_first_q ? last_q : item_i.stamp;

  // Jump check, forward and across the wrap.
  assign back_step = (last_eff > item_i.stamp);
  assign fwd_diff  = item_i.stamp - last_eff;
  assign wsum      = {2'b00, item_i.stamp} + kgpu_pkg::WRAP_MS - {2'b00, last_eff};
  assign jump_bad  = (!back_step && (fwd_diff > {11'd0, jump_q})) ||
                     (back_step && !wsum[28] && (wsum[27:0] > {12'd0, jump_q}));

  // Extended stamp and record time.
  assign k_new   = wrap_q + {2'b00, back_step};
  assign ext_new = {3'b000, item_i.stamp} + kgpu_pkg::wrap_offset(k_new);
  assign rec_new = {1'b0, ext_new} - {4'b0000, first_eff};

  assign vid_ok = session_q && item_i.vsize_ok && (started_q || item_i.start_nal);

  // Next state and result.
  always_comb begin
    session_d    = session_q;
    codec_d      = codec_q;
    jump_d       = jump_q;
    started_d    = started_q;
    have_first_d = have_first_q;
    first_d      = first_q;
    last_d       = last_q;
    wrap_d       = wrap_q;
    bytes_d      = bytes_q;
    status_d     = kgpu_pkg::ST_REJECT;
    ext_d        = '0;
    rec_d        = '0;

    if (take) begin
      case (item_i.op)
        kgpu_pkg::OP_CLOSE: begin
          status_d = kgpu_pkg::ST_KEEP;
          if (codec_known) begin
            session_d    = 1'b0;
            started_d    = 1'b0;
            have_first_d = 1'b0;
            first_d      = '0;
            last_d       = '0;
            wrap_d       = '0;
            bytes_d      = '0;
          end
        end
        kgpu_pkg::OP_AUDIO: begin
          if (session_q && item_i.asize_ok && started_q) begin
            ext_d = {3'b000, item_i.stamp};
            if (item_i.audio_short) begin
              status_d = kgpu_pkg::ST_KEEP;
            end else begin
              status_d = kgpu_pkg::ST_FORWARD;
              bytes_d  = bytes_q + {16'd0, item_i.size};
            end
          end
        end
        kgpu_pkg::OP_VIDEO: begin
          if (vid_ok) begin
            started_d    = 1'b1;
            have_first_d = 1'b1;
            first_d      = first_eff;
            last_d       = item_i.stamp;
            if (!jump_bad) begin
              wrap_d = k_new;
              if (!rec_new[30]) begin
                ext_d = ext_new;
                rec_d = rec_new[29:0];
                if (codec_known) begin
                  status_d = kgpu_pkg::ST_FORWARD;
                  bytes_d  = bytes_q + {16'd0, item_i.size};
                end else begin
                  status_d = kgpu_pkg::ST_KEEP;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Register writes must arrive only while the block is idle; the block itself does not enforce this.
    if (cfg_we_i) begin
      case (cfg_idx_i)
        kgpu_pkg::REG_SESSION: session_d = cfg_wdata_i[0];
        kgpu_pkg::REG_CODEC:   codec_d   = cfg_wdata_i[1:0];
        kgpu_pkg::REG_JUMP:    jump_d    = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Control and session state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_q    <= 1'b0;
      codec_q      <= kgpu_pkg::CODEC_H264;
      jump_q       <= kgpu_pkg::JUMP_RESET;
      started_q    <= 1'b0;
      have_first_q <= 1'b0;
      first_q      <= '0;
      last_q       <= '0;
      wrap_q       <= '0;
      bytes_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      session_q    <= session_d;
      codec_q      <= codec_d;
      jump_q       <= jump_d;
      started_q    <= started_d;
      have_first_q <= have_first_d;
      first_q      <= first_d;
      last_q       <= last_d;
      wrap_q       <= wrap_d;
      bytes_q      <= bytes_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      ext_q    <= ext_d;
      rec_q    <= rec_d;
      total_q  <= bytes_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign ext_o       = ext_q;
  assign rec_o       = rec_q;
  assign total_o     = total_q;

endmodule

`default_nettype wire

// File: src/keyframe_gate_pts_unwrap.sv
// An accepted item is written into the queue, then taken by the back end into the result register, which offers it.
// Throughput: one item per cycle while m_axis_tready does not hold the result; the back end's
// state update (stamp compare, carry offset add, byte count add) sets that pace.
// A two-entry queue between front and back holds items while the output stalls.
// Reset (rst_ni low, asynchronous) clears the session, empties the queue and
// the result register, and loads the registers with their reset values.
`default_nettype none

module keyframe_gate_pts_unwrap (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  // Input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: frame_size, head_byte0, head_byte1, head_byte2, head_byte3, head_byte4, stamp_ms
  input  wire logic [kgpu_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // tuser: opcode
  input  wire logic [1:0]  s_axis_tuser,
  // Result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: extended_stamp, record_time, byte_total
  output logic [kgpu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: status
  output logic [1:0]       m_axis_tuser
);

  kgpu_pkg::cls_t cls_in;
  kgpu_pkg::cls_t cls_out;
  logic           q_full, q_valid, q_pop;
  logic [1:0]     codec;
  logic [29:0]    ext, rec;
  logic [39:0]    total;

  // Classify the incoming item.
  kgpu_front u_front (
    .opcode_i     (s_axis_tuser),
    .frame_size_i (s_axis_tdata[23:0]),
    .head_byte0_i (s_axis_tdata[31:24]),
    .head_byte1_i (s_axis_tdata[39:32]),
    .head_byte2_i (s_axis_tdata[47:40]),
    .head_byte3_i (s_axis_tdata[55:48]),
    .head_byte4_i (s_axis_tdata[63:56]),
    .stamp_ms_i   (s_axis_tdata[90:64]),
    .codec_i      (codec),
    .cls_o        (cls_in)
  );

  assign s_axis_tready = !q_full;

  // Queue of classified items.
  kgpu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .data_i  (cls_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (cls_out)
  );

  // Session state and result register.
  kgpu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .codec_o      (codec),
    .item_valid_i (q_valid),
    .item_i       (cls_out),
    .item_pop_o   (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .status_o     (m_axis_tuser),
    .ext_o        (ext),
    .rec_o        (rec),
    .total_o      (total)
  );

  assign m_axis_tdata = {4'd0, total, rec, ext};

endmodule

`default_nettype wire

// File: src/kgpu_checker.sv
// Port-level checker of the keyframe gate and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module kgpu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [kgpu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  logic        out_stall;
  logic        out_reject;
  logic [29:0] out_ext;
  logic [29:0] out_rec;

  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_reject = m_axis_tvalid && (m_axis_tuser == kgpu_pkg::ST_REJECT);
  assign out_ext    = m_axis_tdata[29:0];
  assign out_rec    = m_axis_tdata[59:30];

  // A rejected item carries neither a stamp nor a record time.
  `ASSERT_SAME(a_reject_zero, out_reject, (out_ext == 30'd0) && (out_rec == 30'd0))

  // Record time is the extended stamp less a non-negative first stamp.
  `ASSERT_SAME(a_rec_le_ext, m_axis_tvalid, out_rec <= out_ext)

  // A stalled result stays offered.
  `ASSERT_NEXT(a_stall_valid, out_stall, m_axis_tvalid)

  // A stalled result keeps its payload.
  `ASSERT_NEXT(a_stall_data, out_stall, $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind keyframe_gate_pts_unwrap kgpu_checker u_kgpu_checker (.*);

`default_nettype wire
